>>> src/lfpd_pkg.sv
// lfpd_pkg: shared types, register indexes and arithmetic constants
// for the line follower pid drive; no dependencies
package lfpd_pkg;

  // field and state widths
  localparam int NUM_SENSE  = 6;
  localparam int GAIN_W     = 16;
  localparam int BASE_W     = 8;
  localparam int TICK_W     = 16;
  localparam int ERR_W      = 4;
  localparam int DRIVE_W    = 8;
  localparam int INTEG_W    = 32;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_W      = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS  = 3'd4;

  localparam logic [TICK_W-1:0] TICKS_RESET = 16'd1071;

  // sensor thresholds for 12-bit samples, and the position weights
  localparam int unsigned THRESH12 [NUM_SENSE] = '{1400, 890, 1000, 1000, 1030, 950};
  localparam logic signed [ERR_W-1:0] WEIGHT [NUM_SENSE] =
    '{-4'sd7, -4'sd3, 4'sd0, 4'sd0, 4'sd3, 4'sd7};

  // pid timing constants
  localparam int SAMPLE_TIME     = 28;
  localparam int INV_SAMPLE_TIME = 35;
  localparam int TRAP_DIV        = 2000;
  localparam int DRIVE_MAX       = 255;

  // trapezoid term: g*28*s/2000 = g*7*s/500, the /500 done by a
  // reciprocal multiply (exact for the operand range used here)
  localparam int TRAP_NUM    = SAMPLE_TIME / 4;
  localparam int TRAP_DEN    = TRAP_DIV / 4;
  localparam int RECIP_SHIFT = 32;
  localparam longint unsigned TRAP_RECIP =
    ((64'd1 << RECIP_SHIFT) + TRAP_DEN - 1) / TRAP_DEN;
  localparam int TRAP_MUL_W = 26;
  localparam logic [TRAP_MUL_W-1:0] TRAP_MUL = TRAP_MUL_W'(TRAP_RECIP * TRAP_NUM);

  localparam logic [15:0] DRIVE_TOP = 16'(DRIVE_MAX * 256);

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [BASE_W-1:0] base_speed;
    logic [TICK_W-1:0] ticks;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic [NUM_SENSE-1:0]    flags;
  } sense_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err_cur;
    logic signed [ERR_W-1:0] err_prev;
    sense_t                  sense;
  } item_t;

  typedef struct packed {
    logic [NUM_SENSE-1:0]    line_flags;
    logic signed [ERR_W-1:0] line_error;
    logic [DRIVE_W-1:0]      right_drive;
    logic [DRIVE_W-1:0]      left_drive;
  } result_t;

endpackage

>>> src/lfpd_sense.sv
// lfpd_sense: threshold compare of the six line sensors and error select
// depends on lfpd_pkg
module lfpd_sense #(
  parameter int ADC_BITS = 12
) (
  input  logic [lfpd_pkg::NUM_SENSE*ADC_BITS-1:0] samples,
  input  logic signed [lfpd_pkg::ERR_W-1:0]       err_hold,
  output lfpd_pkg::sense_t                         sense
);
  import lfpd_pkg::*;

  localparam int SHIFT_UP = (ADC_BITS > 12) ? (ADC_BITS - 12) : 0;
  localparam int SHIFT_DN = (ADC_BITS < 12) ? (12 - ADC_BITS) : 0;

  logic [NUM_SENSE-1:0] above;

  // per sensor compare against its scaled threshold
  for (genvar k = 0; k < NUM_SENSE; k++) begin : g_cmp
    localparam logic [THR_W-1:0] THR = THR_W'((THRESH12[k] << SHIFT_UP) >> SHIFT_DN);
    assign above[k] = THR_W'(samples[k*ADC_BITS +: ADC_BITS]) > THR;
  end

  // highest numbered sensor above threshold wins, else the error holds
  always_comb begin
    sense.flags = above;
    sense.err   = err_hold;
    for (int k = 0; k < NUM_SENSE; k++) begin
      if (above[k]) begin
        sense.err = WEIGHT[k];
      end
    end
  end

endmodule

>>> src/lfpd_pid.sv
// lfpd_pid: pid term stages, integral accumulator and drive clamp
// depends on lfpd_pkg
module lfpd_pid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              s1_v,
  input  lfpd_pkg::item_t   s1_item,
  input  lfpd_pkg::cfg_t    cfg,
  output logic              out_v,
  output lfpd_pkg::result_t result
);
  import lfpd_pkg::*;

  localparam int P_W   = GAIN_W + ERR_W + 1;
  localparam int DD_W  = ERR_W + 1;
  localparam int DA_W  = GAIN_W + DD_W + 1;
  localparam int D_W   = DA_W + 6;
  localparam int MAG_W = ERR_W;
  localparam int GM_W  = GAIN_W + MAG_W;
  localparam int PR_W  = GM_W + TRAP_MUL_W;
  localparam int Q_W   = PR_W - RECIP_SHIFT;
  localparam int DI_W  = Q_W + 1;
  localparam int PD_W  = D_W + 1;
  localparam int PID_W = INTEG_W + 2;
  localparam int DRV_W = PID_W + 1;

  function automatic logic [DRIVE_W-1:0] drive_of(input logic signed [DRV_W-1:0] v);
    logic [DRIVE_W-1:0] r;
    if (v[DRV_W-1]) begin
      r = '0;
    end else if (v > $signed(DRV_W'(DRIVE_TOP))) begin
      r = DRIVE_W'(DRIVE_MAX);
    end else begin
      r = v[2*DRIVE_W-1:DRIVE_W];
    end
    return r;
  endfunction

  // stage valids and accumulator state
  logic v2_r, v3_r, v4_r, v5_r, out_v_r;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic [TICK_W-1:0]         cnt_r, cnt_nxt;

  // stage 2: products of gains with the stored errors
  logic signed [DD_W-1:0]  diff_s, sum_s;
  logic [MAG_W-1:0]        mag;
  logic signed [P_W-1:0]   p_nxt, p2_r, p3_r;
  logic signed [DA_W-1:0]  da_nxt, da2_r;
  logic [GM_W-1:0]         gm_nxt, gm2_r;
  logic                    neg2_r;
  sense_t                  res2_r, res3_r, res4_r, res5_r;

  assign diff_s = DD_W'(s1_item.err_cur) - DD_W'(s1_item.err_prev);
  assign sum_s  = DD_W'(s1_item.err_cur) + DD_W'(s1_item.err_prev);
  assign mag    = sum_s[DD_W-1] ? MAG_W'(-sum_s) : MAG_W'(sum_s);
  assign p_nxt  = $signed({1'b0, cfg.gain_p}) * P_W'(s1_item.err_cur);
  assign da_nxt = $signed({1'b0, cfg.gain_d}) * DA_W'(diff_s);
  assign gm_nxt = GM_W'(cfg.gain_i) * GM_W'(mag);

  // stage 3: derivative scale and trapezoid divide by reciprocal
  logic signed [D_W-1:0]  d_nxt, d3_r;
  logic [PR_W-1:0]        prod;
  logic [Q_W-1:0]         quo;
  logic signed [DI_W-1:0] di_nxt, di3_r;

  assign d_nxt  = D_W'(da2_r) * D_W'(INV_SAMPLE_TIME);
  assign prod   = PR_W'(gm2_r) * PR_W'(TRAP_MUL);
  assign quo    = prod[PR_W-1:RECIP_SHIFT];
  assign di_nxt = neg2_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  // stage 4: saturating integral and reset period counter
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W-1:0] isat, ig4_r;
  logic [TICK_W-1:0]         cnt_inc;
  logic                      hit;
  logic signed [PD_W-1:0]    pd_nxt, pd4_r;

  assign isum    = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(di3_r);
  assign isat    = (isum[INTEG_W] != isum[INTEG_W-1]) ?
                   {isum[INTEG_W], {(INTEG_W-1){~isum[INTEG_W]}}} : isum[INTEG_W-1:0];
  assign cnt_inc = TICK_W'(cnt_r + 1'b1);
  assign hit     = cnt_inc >= cfg.ticks;
  assign pd_nxt  = PD_W'(p3_r) + PD_W'(d3_r);

  always_comb begin
    integ_nxt = integ_r;
    cnt_nxt   = cnt_r;
    if (adv && v3_r) begin
      integ_nxt = hit ? '0 : isat;
      cnt_nxt   = hit ? '0 : cnt_inc;
    end
  end

  // stage 5: full pid sum; output: base plus and minus, clamped
  logic signed [PID_W-1:0] pid_nxt, pid5_r;
  logic signed [DRV_W-1:0] base_q, lsum, rsum;
  result_t                 result_r;

  assign pid_nxt = PID_W'(pd4_r) + PID_W'(ig4_r);
  assign base_q  = $signed(DRV_W'({cfg.base_speed, 8'h00}));
  assign lsum    = base_q + DRV_W'(pid5_r);
  assign rsum    = base_q - DRV_W'(pid5_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      out_v_r <= 1'b0;
      integ_r <= '0;
      cnt_r   <= '0;
    end else begin
      integ_r <= integ_nxt;
      cnt_r   <= cnt_nxt;
      if (adv) begin
        v2_r    <= s1_v;
        v3_r    <= v2_r;
        v4_r    <= v3_r;
        v5_r    <= v4_r;
        out_v_r <= v5_r;
      end
    end
  end

  // payload shift, all stages move together
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r     <= p_nxt;
      da2_r    <= da_nxt;
      gm2_r    <= gm_nxt;
      neg2_r   <= sum_s[DD_W-1];
      res2_r   <= s1_item.sense;
      p3_r     <= p2_r;
      d3_r     <= d_nxt;
      di3_r    <= di_nxt;
      res3_r   <= res2_r;
      pd4_r    <= pd_nxt;
      ig4_r    <= isat;
      res4_r   <= res3_r;
      pid5_r   <= pid_nxt;
      res5_r   <= res4_r;
      result_r <= '{line_flags:  res5_r.flags,
                    line_error:  res5_r.err,
                    right_drive: drive_of(rsum),
                    left_drive:  drive_of(lsum)};
    end
  end

  assign out_v  = out_v_r;
  assign result = result_r;

  // checks
  a_reset_idle : assert property (@(posedge clk) !rst_n |=> !out_v_r)
    else $error("result valid right after reset");
  a_integ_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v3_r && hit) |=> (integ_r == '0 && cnt_r == '0))
    else $error("integral not cleared at end of reset period");
  a_integ_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && v3_r) |=> ($stable(integ_r) && $stable(cnt_r)))
    else $error("integral moved without a transaction");

endmodule

>>> src/line_follow_pid_drive.sv
// line_follow_pid_drive: line follower pid steering for a differential drive
// pipeline: input stage, stage 2, stage 3, stage 4, stage 5 and output registers
// throughput: one transaction per cycle unless a held output (out_tready low) stalls the
// whole pipeline; the integral add and saturate is a registered loop in stage 4, every other stage is feed-forward
// reset: synchronous active-low rst_n clears errors, integral, tick count,
// valids and registers (gains and base 0, integral period 1071)
module line_follow_pid_drive #(
  parameter  int ADC_BITS = 12,
  localparam int IN_W     = ((lfpd_pkg::NUM_SENSE * ADC_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sense_far_left, sense_left, sense_mid_left, sense_mid_right,
  // sense_right, sense_far_right (ADC_BITS each), zero pad
  input  logic [IN_W-1:0]                 in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // left_drive[7:0], right_drive[15:8], line_error[19:16],
  // line_flags[25:20], zero pad
  output logic [lfpd_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_we,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lfpd_pkg::*;

  cfg_t                    cfg_r;
  logic signed [ERR_W-1:0] error_now_r, error_before_r;
  logic                    s1_v_r;
  item_t                   s1_item_r;
  sense_t                  sense;
  logic                    adv, in_acc, out_v;
  result_t                 result;

  // whole pipeline moves when the output register is free
  assign adv       = !out_v || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p     <= '0;
      cfg_r.gain_i     <= '0;
      cfg_r.gain_d     <= '0;
      cfg_r.base_speed <= '0;
      cfg_r.ticks      <= TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_GAIN_P: cfg_r.gain_p     <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I: cfg_r.gain_i     <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D: cfg_r.gain_d     <= cfg_data[GAIN_W-1:0];
        CFG_BASE:   cfg_r.base_speed <= cfg_data[BASE_W-1:0];
        CFG_TICKS:  cfg_r.ticks      <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // sensor compare on the incoming transaction
  lfpd_sense #(
    .ADC_BITS (ADC_BITS)
  ) u_sense (
    .samples  (in_tdata[NUM_SENSE*ADC_BITS-1:0]),
    .err_hold (error_now_r),
    .sense    (sense)
  );

  // error history and input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_now_r    <= '0;
      error_before_r <= '0;
      s1_v_r         <= 1'b0;
    end else begin
      if (adv) begin
        s1_v_r <= in_tvalid;
      end
      if (in_acc) begin
        error_before_r <= error_now_r;
        error_now_r    <= sense.err;
      end
    end
  end

  // input stage payload: errors the pid step uses plus the new sense result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= '{err_cur: error_now_r, err_prev: error_before_r, sense: sense};
    end
  end

  lfpd_pid u_pid (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .s1_v    (s1_v_r),
    .s1_item (s1_item_r),
    .cfg     (cfg_r),
    .out_v   (out_v),
    .result  (result)
  );

  assign out_tvalid = out_v;
  assign out_tdata  = OUT_W'(result);

  // checks
  a_err_legal : assert property (@(posedge clk) disable iff (!rst_n)
    (error_now_r == WEIGHT[0] || error_now_r == WEIGHT[1] || error_now_r == WEIGHT[2] ||
     error_now_r == WEIGHT[4] || error_now_r == WEIGHT[5]))
    else $error("line error outside the weight set");
  a_err_shift : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> error_before_r == $past(error_now_r))
    else $error("previous error not taken from current error");
  a_err_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> ($stable(error_now_r) && $stable(error_before_r)))
    else $error("error history moved without a transaction");

endmodule
